// ===== src/dhct_pkg.sv =====
`default_nettype none
package dhct_pkg;

    localparam int DEPTH_W    = 25;
    localparam int FRAC_W     = 24;
    localparam int WORD_W     = 32;
    localparam int TOL_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STAGES = WORD_W;
    // product stage + denominator stage + one stage per quotient bit + output stage
    localparam int LANE_LAT   = DIV_STAGES + 3;
    // two compare stages follow the lanes
    localparam int PIPE_LAST  = LANE_LAT + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR    = 3'd0,
        CFG_FAR     = 3'd1,
        CFG_REL_TOL = 3'd2,
        CFG_MIN_TOL = 3'd3
    } t_cfg_idx;

endpackage
`default_nettype wire

// ===== src/dhct_lane.sv =====
`default_nettype none
module dhct_lane
    import dhct_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [FRAC_W-1:0]     i_depth,
    input  wire logic [WORD_W-1:0]     i_span,
    input  wire logic [WORD_W-1:0]     i_far,
    input  wire logic [2*WORD_W-1:0]   i_nf,
    output logic      [WORD_W-1:0]     o_lin
);

    localparam int PROD_W = FRAC_W + WORD_W;

    logic [PROD_W-1:0] w_prod;
    logic [WORD_W-1:0] r_pt;
    logic [WORD_W-1:0] n_den0;

    logic [WORD_W-1:0] r_rem [0:DIV_STAGES];
    logic [WORD_W-1:0] r_den [0:DIV_STAGES];
    logic [WORD_W-1:0] r_q   [0:DIV_STAGES];
    logic              r_sat [0:DIV_STAGES];
    logic [WORD_W-1:0] n_rem [1:DIV_STAGES];
    logic [WORD_W-1:0] n_q   [1:DIV_STAGES];
    logic [WORD_W-1:0] r_lin;

    assign w_prod = PROD_W'(i_depth) * PROD_W'(i_span);

    always_comb begin
        n_den0 = i_far - r_pt;
        if (n_den0 == '0) begin
            n_den0 = WORD_W'(1);
        end
    end

    // one restoring step per stage; dividend low bits come straight from the constant product
    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            logic [WORD_W:0] sh;
            sh = {r_rem[k], i_nf[WORD_W-1-k]};
            if (sh >= {1'b0, r_den[k]}) begin
                n_rem[k+1] = WORD_W'(sh - {1'b0, r_den[k]});
                n_q[k+1]   = {r_q[k][WORD_W-2:0], 1'b1};
            end else begin
                n_rem[k+1] = sh[WORD_W-1:0];
                n_q[k+1]   = {r_q[k][WORD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt     <= w_prod[PROD_W-1:FRAC_W];
            r_den[0] <= n_den0;
            r_rem[0] <= i_nf[2*WORD_W-1:WORD_W];
            r_q[0]   <= '0;
            r_sat[0] <= i_nf[2*WORD_W-1:WORD_W] >= n_den0;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_den[k] <= r_den[k-1];
                r_sat[k] <= r_sat[k-1];
            end
            r_lin <= r_sat[DIV_STAGES] ? '1 : r_q[DIV_STAGES];
        end
    end

    assign o_lin = r_lin;

endmodule
`default_nettype wire

// ===== src/depth_history_compatibility_test.sv =====
// Depth history compatibility test.
// Input channel (i_valid / o_ready) carries one pixel request: the current and
// history device depths, unsigned 1.24. Output channel (o_valid / i_ready)
// returns one result per pixel with o_compatible, in input order.
// Configuration: write near, far, relative and minimum tolerance through
// i_cfg_we / i_cfg_index / i_cfg_data, only while no pixel is in flight.
// Throughput: one pixel per clock while the output is not stalled. Pipeline,
// in order: input register, 24x32 product, denominator, 32 restoring divider
// stages at one quotient bit each, lane output, two compare stages.
// The divider chain makes up most of it; both depths run in parallel lanes.
// Reset restores the default planes and tolerances and empties the pipeline.
// When the receiver stalls with a finished result at the output, the whole
// pipeline holds; o_ready drops only then, so nothing is lost or repeated.
`default_nettype none
module depth_history_compatibility_test
    import dhct_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [DEPTH_W-1:0]   i_current_device_depth,
    input  wire logic [DEPTH_W-1:0]   i_history_device_depth,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_compatible,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    localparam int REL_W = WORD_W + TOL_W;
    localparam int TOLF_W = REL_W - 16;

    logic [WORD_W-1:0]   r_near, r_far, r_min_tol;
    logic [TOL_W-1:0]    r_rel_tol;
    logic [WORD_W-1:0]   r_span;
    logic [2*WORD_W-1:0] r_nf;
    logic                w_degen;
    logic                w_en;

    logic                r_v   [0:PIPE_LAST];
    logic                r_rej [0:PIPE_LAST];
    logic [FRAC_W-1:0]   r_cur, r_his;
    logic [WORD_W-1:0]   w_lin_c, w_lin_h, w_lc, w_lh;
    logic [WORD_W-1:0]   r_diff;
    logic [TOLF_W-1:0]   r_rel;
    logic [REL_W-1:0]    w_rel_full;
    logic [TOLF_W-1:0]   w_tol;
    logic                r_out;

    // write the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near    <= WORD_W'(65536);
            r_far     <= WORD_W'(65536000);
            r_rel_tol <= TOL_W'(655);
            r_min_tol <= WORD_W'(3277);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NEAR:    r_near    <= i_cfg_data;
                CFG_FAR:     r_far     <= i_cfg_data;
                CFG_REL_TOL: r_rel_tol <= i_cfg_data[TOL_W-1:0];
                CFG_MIN_TOL: r_min_tol <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // plane terms follow the registers; they settle long before any request uses them
    always_ff @(posedge i_clk) begin
        r_span <= r_far - r_near;
        r_nf   <= (2*WORD_W)'(r_near) * (2*WORD_W)'(r_far);
    end

    // a zero near plane or a far plane not beyond near flattens both depths to zero
    assign w_degen = (r_near == '0) || (r_far <= r_near);

    // advance everything together unless a result waits unclaimed
    assign w_en    = !r_v[PIPE_LAST] || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= PIPE_LAST; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= PIPE_LAST; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cur  <= i_current_device_depth[FRAC_W-1:0];
            r_his  <= i_history_device_depth[FRAC_W-1:0];
            r_rej[0] <= i_current_device_depth[FRAC_W] || i_history_device_depth[FRAC_W];
            for (int k = 1; k <= PIPE_LAST; k++) begin
                r_rej[k] <= r_rej[k-1];
            end
        end
    end

    dhct_lane u_lane_cur (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_depth (r_cur),
        .i_span  (r_span),
        .i_far   (r_far),
        .i_nf    (r_nf),
        .o_lin   (w_lin_c)
    );

    dhct_lane u_lane_his (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_depth (r_his),
        .i_span  (r_span),
        .i_far   (r_far),
        .i_nf    (r_nf),
        .o_lin   (w_lin_h)
    );

    assign w_lc       = w_degen ? '0 : w_lin_c;
    assign w_lh       = w_degen ? '0 : w_lin_h;
    assign w_rel_full = REL_W'(w_lc) * REL_W'(r_rel_tol);
    assign w_tol      = (r_rel > TOLF_W'(r_min_tol)) ? r_rel : TOLF_W'(r_min_tol);

    // first compare stage: difference and relative tolerance; second: the decision
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_diff <= (w_lc >= w_lh) ? (w_lc - w_lh) : (w_lh - w_lc);
            r_rel  <= w_rel_full[REL_W-1:16];
            r_out  <= !r_rej[PIPE_LAST-1] && (TOLF_W'(r_diff) <= w_tol);
        end
    end

    assign o_valid      = r_v[PIPE_LAST];
    assign o_compatible = r_out;

    a_rej_never_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_rej[PIPE_LAST]) |-> !o_compatible)
        else $error("rejected depth reported compatible");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_v[0]) && $stable(r_v[LANE_LAT]) && $stable(r_diff)))
        else $error("pipeline moved during stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v[0])
        else $error("accepted request not captured");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

// ===== bench/tb_depth_history_compatibility_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_depth_history_compatibility_test;
    import dhct_pkg::*;

    // Predicted compatibility verdicts in request order, checked against o_compatible.
    class verdict_board;
        bit          verdicts[$];
        int unsigned errors;
        logic [63:0] near_q, far_q, rel_q, min_q;

        function void set_planes(logic [63:0] n, logic [63:0] f, logic [63:0] r,
                                 logic [63:0] m);
            near_q = n;
            far_q  = f;
            rel_q  = r;
            min_q  = m;
        endfunction

        // Linear 16.16 depth for a device depth below 1.0, saturating at 32 bits.
        function logic [63:0] linearise(logic [63:0] d);
            logic [63:0] span, den, quo;
            if (near_q == 0 || far_q <= near_q) return 64'd0;
            span = far_q - near_q;
            den  = far_q - ((d * span) >> 24);
            if (den < 1) den = 1;
            quo = (near_q * far_q) / den;
            if (quo > 64'hFFFF_FFFF) quo = 64'hFFFF_FFFF;
            return quo;
        endfunction

        function void note_request(logic [DEPTH_W-1:0] cur_d, logic [DEPTH_W-1:0] his_d);
            logic [63:0] cur, his, diff, tol;
            if (cur_d >= (1 << FRAC_W) || his_d >= (1 << FRAC_W)) begin
                verdicts.push_back(1'b0);
                return;
            end
            cur  = linearise(64'(cur_d));
            his  = linearise(64'(his_d));
            diff = (cur >= his) ? cur - his : his - cur;
            tol  = (cur * rel_q) >> 16;
            if (tol < min_q) tol = min_q;
            verdicts.push_back(diff <= tol);
        endfunction

        function void check_verdict(bit got);
            bit want;
            if (verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0b", $time, got);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            if (want !== got) begin
                $display("%0t: compatible mismatch, expected %0b, actual %0b",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [DEPTH_W-1:0]   i_current_device_depth = '0;
    logic [DEPTH_W-1:0]   i_history_device_depth = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_compatible;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    verdict_board board;
    bit           quiet_tail;      // no idling in the last part of the run
    bit           long_hold;       // ask the receiver for one long stall

    depth_history_compatibility_test u_top (.*);

    always #5 i_clk = ~i_clk;

    // Write one register while nothing is in flight; keep the model in step.
    task automatic write_reg(t_cfg_idx idx, logic [WORD_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_NEAR:    board.near_q = 64'(value);
            CFG_FAR:     board.far_q  = 64'(value);
            CFG_REL_TOL: board.rel_q  = 64'(value[TOL_W-1:0]);
            CFG_MIN_TOL: board.min_q  = 64'(value);
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] n, logic [31:0] f, logic [23:0] r, logic [31:0] m);
        write_reg(CFG_NEAR, n);
        write_reg(CFG_FAR, f);
        write_reg(CFG_REL_TOL, {8'd0, r});
        write_reg(CFG_MIN_TOL, m);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one request and hold it until accepted; idle first at random.
    task automatic send_request(logic [DEPTH_W-1:0] cur, logic [DEPTH_W-1:0] his);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid                <= 1'b1;
        i_current_device_depth <= cur;
        i_history_device_depth <= his;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(cur, his);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (board.verdicts.size() != 0) @(posedge i_clk);
        repeat (LANE_LAT + 8) @(posedge i_clk);
    endtask

    // Mostly below 1.0, often near the ends, sometimes at or above it.
    function automatic logic [DEPTH_W-1:0] pick_depth();
        case ($urandom_range(0, 9))
            0:       return DEPTH_W'($urandom_range(0, 255));
            1:       return DEPTH_W'((1 << FRAC_W) - 1 - $urandom_range(0, 4095));
            2:       return DEPTH_W'($urandom_range(1 << FRAC_W, (1 << DEPTH_W) - 1));
            default: return DEPTH_W'($urandom_range(0, (1 << FRAC_W) - 1));
        endcase
    endfunction

    // Receiver: random bursts of stall, one long hold when asked.
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                long_hold = 1'b0;
                i_ready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && i_ready) board.check_verdict(o_compatible);

    initial begin
        logic [DEPTH_W-1:0] d;
        board = new();
        board.set_planes(65536, 65536000, 655, 3277);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: depth extremes with reset planes.
        send_request(0, 0);
        send_request(0, (1 << FRAC_W) - 1);
        send_request((1 << FRAC_W) - 1, (1 << FRAC_W) - 1);
        send_request(1 << FRAC_W, 0);
        send_request(0, 1 << FRAC_W);
        send_request('1, '1);
        send_request(25'h080_0000, 25'h080_0001);
        send_request(25'h0FF_FF00, 25'h0FF_FFF0);
        drain();
        // Degenerate planes: near zero, then far not above near.
        set_all(0, 32'd65536000, 655, 3277);
        send_request(12345, 999999);
        send_request(1 << FRAC_W, 5);
        drain();
        set_all(32'd1000000, 32'd1000000, 655, 3277);
        send_request(7, 16000000);
        drain();
        // Extremes: far just below near, saturating linear depths, full and zero tolerances.
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFE, 24'hFF_FFFF, 32'hFFFF_FFFF);
        send_request(3, 4);
        drain();
        set_all(32'd1, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
        send_request((1 << FRAC_W) - 1, 0);
        send_request(0, (1 << FRAC_W) - 1);
        drain();
        set_all(32'd1, 32'hFFFF_FFFF, 0, 0);
        send_request((1 << FRAC_W) - 1, (1 << FRAC_W) - 2);
        send_request(100, 100);
        drain();

        // Random phases with fresh settings between them.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) quiet_tail = 1'b1;
            set_all($urandom_range(1, 1 << 20), $urandom_range(1 << 20, 32'hFFFF_FFFF),
                    24'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 23)),
                    $urandom >> $urandom_range(0, 31));
            if (ph == 2) long_hold = 1'b1;
            for (int k = 0; k < 200; k++) begin
                d = pick_depth();
                if ($urandom_range(0, 2) == 0)
                    send_request(d, d);
                else if ($urandom_range(0, 1))
                    send_request(d, d ^ DEPTH_W'(1 << $urandom_range(0, DEPTH_W - 1)));
                else
                    send_request(d, pick_depth());
            end
            drain();
        end
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
